FILE: rtl/cpa_pkg.sv
// cpa_pkg: shared constants, codes and helpers for the chunk pool allocator
// used by chunk_pool_allocator_top; no dependencies
package cpa_pkg;

    localparam int MAX_CHUNKS  = 64;
    localparam int CHUNK_BYTES = 64;

    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
    localparam int IDX_W       = $clog2(MAX_CHUNKS);
    localparam int SIZE_W      = 13;
    localparam int OFF_W       = 12;
    localparam int CNT_W       = SIZE_W + 1 - CHUNK_SHIFT;
    localparam int CUR_W       = CNT_W - 1;

    localparam logic [SIZE_W-1:0] POOL_CAP   = SIZE_W'(MAX_CHUNKS * CHUNK_BYTES);
    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(4096);

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_FREE     = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_ALIGN   = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // round a byte count up to whole chunks
    function automatic logic [CNT_W-1:0] ceil_chunks(input logic [SIZE_W-1:0] bytes);
        logic [SIZE_W:0] sum;
        sum = {1'b0, bytes} + (SIZE_W + 1)'(CHUNK_BYTES - 1);
        return sum[SIZE_W:CHUNK_SHIFT];
    endfunction

endpackage

FILE: rtl/cpa_ram.sv
// cpa_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/chunk_pool_allocator_top.sv
// chunk_pool_allocator_top: next-fit allocator over a pool of fixed-size chunks
// depends on cpa_pkg and cpa_ram
//
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | tuser: op; tdata: req_size, free_offset
// m_      | out | m_tvalid/m_tready | tuser: status; tdata: block_offset
// cfg_    | in  | cfg_we            | cfg_wdata: pool_bytes
//
// free, free-all and unused ops: accepted in S_IDLE, then S_RESP loads the output register
// allocate: each run head visited takes S_READ (ram read), then S_EVAL (evaluate); on no room
//   a last S_READ ends the scan; S_RESP then loads the output register
// the scan loop shares one table ram read port; one step value feeds the cursor and skip adders
// reset clears the used table through per-chunk valid bits and the cursor, and sets pool size to 4096
// a word waiting on m_tready holds the next result in S_RESP; s_tready is low until it moves
module chunk_pool_allocator_top
    import cpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size[12:0], free_offset[24:13], zero
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // block_offset[11:0], zero
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [SIZE_W-1:0]       pool_reg;
    logic [MAX_CHUNKS-1:0]   valid_reg, valid_next;
    logic [CUR_W-1:0]        cursor_reg, cursor_next;
    logic [CNT_W-1:0]        cur_reg, cur_next;
    logic [CNT_W-1:0]        skipped_reg, skipped_next;
    logic [CNT_W-1:0]        needed_reg, needed_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [IDX_W-1:0]        cand_reg, cand_next;
    logic                    have_reg, have_next;
    status_t                 status_reg, status_next;
    logic [OFF_W-1:0]        offset_reg, offset_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [OFF_W-1:0]        m_offset_reg, m_offset_next;
    logic                    out_load;

    logic [SIZE_W-1:0]       in_size;
    logic [OFF_W-1:0]        in_off;
    op_t                     in_op;
    logic [SIZE_W-1:0]       pool_sat;
    logic [CNT_W-1:0]        n_chunks;
    logic [IDX_W-1:0]        free_idx;
    logic [IDX_W-1:0]        cur_idx;
    logic [SIZE_W-1:0]       used;
    logic [SIZE_W:0]         head_off;
    logic [SIZE_W:0]         room;
    logic                    fits;
    logic                    have_t;
    logic [IDX_W-1:0]        cand_t;
    logic [CNT_W-1:0]        step_raw;
    logic [CNT_W-1:0]        step;
    logic [CNT_W-1:0]        cur_new;
    logic [CNT_W-1:0]        run_len;
    logic                    grant;

    logic                    ram_we;
    logic                    ram_rd_en;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [SIZE_W-1:0]       ram_rd_data;

    cpa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_CHUNKS)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (cand_t),
        .wr_data (size_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_size  = s_tdata[SIZE_W-1:0];
    assign in_off   = s_tdata[SIZE_W+OFF_W-1:SIZE_W];
    assign in_op    = op_t'(s_tuser);
    assign pool_sat = (pool_reg > POOL_CAP) ? POOL_CAP : pool_reg;
    assign n_chunks = ceil_chunks(pool_sat);
    assign free_idx = in_off[OFF_W-1:CHUNK_SHIFT];

    // evaluate step for the head at cur_reg
    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign used     = valid_reg[cur_idx] ? ram_rd_data : '0;
    assign head_off = (SIZE_W + 1)'(cur_reg) << CHUNK_SHIFT;
    assign room     = {1'b0, pool_sat} - head_off;
    assign fits     = room >= {1'b0, size_reg};

    always_comb
    begin
        have_t = have_reg;
        cand_t = cand_reg;
        if (have_reg)
        begin
            if (used != '0)
            begin
                have_t = 1'b0;
            end
        end
        else if (used == '0 && fits)
        begin
            cand_t = cur_idx;
            have_t = 1'b1;
        end
    end

    assign step_raw = ceil_chunks(used);
    assign step     = (step_raw == '0) ? CNT_W'(1) : step_raw;
    assign cur_new  = cur_reg + step;
    assign run_len  = cur_new - CNT_W'(cand_t);
    assign grant    = (state_reg == S_EVAL) && have_t && (run_len >= needed_reg);
    assign ram_we   = grant;

    // output register
    assign out_load      = (state_reg == S_RESP) && (!m_valid_reg || m_tready);
    assign m_valid_next  = out_load | (m_valid_reg & ~m_tready);
    assign m_status_next = out_load ? status_reg : m_status_reg;
    assign m_offset_next = out_load ? offset_reg : m_offset_reg;

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        cursor_next  = cursor_reg;
        cur_next     = cur_reg;
        skipped_next = skipped_reg;
        needed_next  = needed_reg;
        size_next    = size_reg;
        cand_next    = cand_reg;
        have_next    = have_reg;
        status_next  = status_reg;
        offset_next  = offset_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = cur_idx;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    status_next = ST_OK;
                    offset_next = '0;
                    state_next  = S_RESP;
                    case (in_op)
                        OP_ALLOC:
                        begin
                            size_next    = in_size;
                            needed_next  = ceil_chunks(in_size);
                            cur_next     = CNT_W'(cursor_reg);
                            skipped_next = '0;
                            have_next    = 1'b0;
                            state_next   = S_READ;
                        end
                        OP_FREE:
                        begin
                            if (in_off[CHUNK_SHIFT-1:0] != '0)
                            begin
                                status_next = ST_ALIGN;
                            end
                            else if (CNT_W'(free_idx) >= n_chunks)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                valid_next[free_idx] = 1'b0;
                            end
                        end
                        OP_FREE_ALL:
                        begin
                            valid_next  = '0;
                            cursor_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (skipped_reg >= n_chunks)
                begin
                    status_next = ST_NO_ROOM;
                    offset_next = '0;
                    state_next  = S_RESP;
                end
                else
                begin
                    // wrap drops the candidate
                    if (cur_reg >= n_chunks)
                    begin
                        cur_next    = '0;
                        have_next   = 1'b0;
                        ram_rd_addr = '0;
                    end
                    ram_rd_en  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (grant)
                begin
                    valid_next[cand_t] = 1'b1;
                    cursor_next = (cur_new >= n_chunks) ? '0 : cur_new[CUR_W-1:0];
                    offset_next = OFF_W'(cand_t) << CHUNK_SHIFT;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    cur_next     = cur_new;
                    skipped_next = skipped_reg + step;
                    have_next    = have_t;
                    cand_next    = cand_t;
                    state_next   = S_READ;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pool_reg    <= POOL_RESET;
            valid_reg   <= '0;
            cursor_reg  <= '0;
            have_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pool_reg    <= cfg_we ? cfg_wdata : pool_reg;
            valid_reg   <= valid_next;
            cursor_reg  <= cursor_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        skipped_reg  <= skipped_next;
        needed_reg   <= needed_next;
        size_reg     <= size_next;
        cand_reg     <= cand_next;
        status_reg   <= status_next;
        offset_reg   <= offset_next;
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = 16'(m_offset_reg);

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser) && $stable(m_tdata)))
        else $error("output word changed while stalled");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero block offset on failed request");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(cursor_reg) < CNT_W'(MAX_CHUNKS))
        else $error("scan cursor beyond table");

    a_eval_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (cur_reg < n_chunks))
        else $error("scan evaluates chunk outside pool");

    a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
        grant |=> (valid_reg[$past(cand_t)] && state_reg == S_RESP))
        else $error("granted head not marked or result missing");
`endif

endmodule
